// ===== rtl/mono_framebuffer_draw_engine_defines.svh =====
// assertion macros for the frame store drawing engine
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MFB_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mfb assertion failed");

// next-cycle implication, checked outside reset
`define MFB_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mfb assertion failed");

`endif

// ===== rtl/mfb_pkg.sv =====
// types, codes and constants of the frame store drawing engine
package mfb_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int WORD_BITS      = 64;

   typedef logic signed [14:0] coord_type;

   localparam logic [3:0] FN_CLEAR   = 4'd0;
   localparam logic [3:0] FN_PUT     = 4'd1;
   localparam logic [3:0] FN_GET     = 4'd2;
   localparam logic [3:0] FN_TOGGLE  = 4'd3;
   localparam logic [3:0] FN_HLINE   = 4'd4;
   localparam logic [3:0] FN_VLINE   = 4'd5;
   localparam logic [3:0] FN_FILL    = 4'd6;
   localparam logic [3:0] FN_INVERT  = 4'd7;
   localparam logic [3:0] FN_OUTLINE = 4'd8;
   localparam logic [3:0] FN_GLYPH   = 4'd9;
   localparam logic [3:0] FN_CGLYPH  = 4'd10;

   localparam logic [2:0] CSR_FRAME_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_CLIP_LEFT    = 3'd2;
   localparam logic [2:0] CSR_CLIP_TOP     = 3'd3;
   localparam logic [2:0] CSR_CLIP_WIDTH   = 3'd4;
   localparam logic [2:0] CSR_CLIP_HEIGHT  = 3'd5;

   localparam logic [9:0]  RST_FRAME_WIDTH  = 10'd512;
   localparam logic [8:0]  RST_FRAME_HEIGHT = 9'd256;
   localparam logic [10:0] RST_CLIP_WIDTH   = 11'd512;
   localparam logic [10:0] RST_CLIP_HEIGHT  = 11'd256;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_READ,
      ST_MODIFY,
      ST_DONE
   } state_type;

   function automatic coord_type cmax(coord_type a, coord_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic coord_type cmin(coord_type a, coord_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== rtl/mfb_store.sv =====
// frame store memory, one write and one registered read port
module mfb_store #(
   parameter int DEPTH = 2048,
   parameter int AW    = 11
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [mfb_pkg::WORD_BITS-1:0]  wr_data,
   input  logic                           rd_en,
   input  logic [AW-1:0]                  rd_addr,
   output logic [mfb_pkg::WORD_BITS-1:0]  rd_data
);
   import mfb_pkg::*;

   logic [WORD_BITS-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/mono_framebuffer_draw_engine.sv =====
// top level of the one-bit-per-pixel frame store drawing engine
//
// req channel: one command per item, func in tuser, geometry and glyph in tdata.
// rsp channel: one item per command, done_func in tuser, pixel_out in tdata.
// csr channel: register writes, always ready; write only while the engine is idle.
// The store lives in 64-pixel words; each row of the frame spans
// ceil(MAX_WIDTH/64) words.
// After reset the engine sweeps the store to zero, one word per cycle, for
// ceil(MAX_WIDTH/64)*MAX_HEIGHT words (2048 at default size) before req_tready rises.
// A clear command takes the same sweep.
// Pixel commands (put, get, toggle) pass the setup state, then for an in-frame pixel a read and a
// modify state (put and toggle write the word back), then the done state that loads the response.
// Area commands pass the setup state once per segment plus a read and a modify state for each
// store word they cover; an outline runs four segments, or none when its width or height is zero.
// Commands are handled one at a time; req_tready is high only in the idle state.
// The response sits in an output register; while rsp_tready is low the next
// command may be accepted and run, and only its completion waits.
module mono_framebuffer_draw_engine #(
   parameter int MAX_WIDTH  = mfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = mfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // x_pos[11:0] y_pos[23:12] span_width[34:24] span_height[45:35]
   // draw_value[46] glyph_bits[54:47] zero[55]
   input  logic [55:0] req_tdata,
   // func[3:0]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // pixel_out[0] zero[7:1]
   output logic [7:0]  rsp_tdata,
   // done_func[3:0]
   output logic [3:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);
   import mfb_pkg::*;

   localparam int WPR   = (MAX_WIDTH + WORD_BITS - 1) / WORD_BITS;
   localparam int DEPTH = WPR * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   state_type state_ff, state_in;

   logic [9:0]         frame_width_ff;
   logic [8:0]         frame_height_ff;
   logic signed [11:0] clip_left_ff, clip_top_ff;
   logic [10:0]        clip_width_ff, clip_height_ff;

   logic [3:0]  func_ff, func_in;
   coord_type   x_ff, x_in, y_ff, y_in;
   logic [10:0] w_ff, w_in, h_ff, h_in;
   logic        dv_ff, dv_in;
   logic [7:0]  gb_ff, gb_in;
   logic [1:0]  seg_ff, seg_in;
   coord_type   x0_ff, x0_in, x1_ff, x1_in, y1_ff, y1_in;
   coord_type   row_ff, row_in, wcol_ff, wcol_in;
   logic        pix_ff, pix_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic        clr_cmd_ff, clr_cmd_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_pix_ff, rsp_pix_in;
   logic [3:0]  rsp_func_ff, rsp_func_in;

   logic                 wr_en, rd_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [WORD_BITS-1:0] wr_data, rd_data;

   coord_type rx, ry, rw, rh, lim_w, lim_h, cx, cy, sx0, sx1, sy0, sy1, c, gi;
   logic      seg_last, seg_ok, glyph, clipped, flip;
   logic      wlast, rlast;
   logic [WORD_BITS-1:0] mask;
   logic [AW-1:0] word_addr;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_pix_ff};
   assign rsp_tuser  = rsp_func_ff;

   assign word_addr = AW'(row_ff * WPR + wcol_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         clip_left_ff    <= '0;
         clip_top_ff     <= '0;
         clip_width_ff   <= RST_CLIP_WIDTH;
         clip_height_ff  <= RST_CLIP_HEIGHT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data[9:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data[8:0];
            CSR_CLIP_LEFT:    clip_left_ff    <= csr_data;
            CSR_CLIP_TOP:     clip_top_ff     <= csr_data;
            CSR_CLIP_WIDTH:   clip_width_ff   <= csr_data[10:0];
            CSR_CLIP_HEIGHT:  clip_height_ff  <= csr_data[10:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_cmd_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_cmd_ff   <= clr_cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      dv_ff       <= dv_in;
      gb_ff       <= gb_in;
      seg_ff      <= seg_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      row_ff      <= row_in;
      wcol_ff     <= wcol_in;
      pix_ff      <= pix_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_func_ff <= rsp_func_in;
   end

   // segment rectangle, clamped to the frame, and to the clip window for clipped glyphs
   always_comb begin
      lim_w   = cmin(coord_type'({1'b0, frame_width_ff}), coord_type'(MAX_WIDTH));
      lim_h   = cmin(coord_type'({1'b0, frame_height_ff}), coord_type'(MAX_HEIGHT));
      cx      = coord_type'(clip_left_ff);
      cy      = coord_type'(clip_top_ff);
      glyph   = (func_ff == FN_GLYPH) || (func_ff == FN_CGLYPH);
      clipped = (func_ff == FN_CGLYPH);
      rx      = x_ff;
      ry      = y_ff;
      rw      = coord_type'(1);
      rh      = coord_type'(1);
      seg_ok  = 1'b1;
      seg_last = 1'b1;
      unique case (func_ff)
         FN_HLINE: rw = coord_type'({1'b0, w_ff});
         FN_VLINE: rh = coord_type'({1'b0, h_ff});
         FN_FILL, FN_INVERT: begin
            rw = coord_type'({1'b0, w_ff});
            rh = coord_type'({1'b0, h_ff});
         end
         FN_OUTLINE: begin
            seg_ok   = (w_ff != '0) && (h_ff != '0);
            seg_last = (seg_ff == 2'd3) || !seg_ok;
            unique case (seg_ff)
               2'd0: rw = coord_type'({1'b0, w_ff});
               2'd1: begin
                  rw = coord_type'({1'b0, w_ff});
                  ry = y_ff + coord_type'({1'b0, h_ff}) - coord_type'(1);
               end
               2'd2: rh = coord_type'({1'b0, h_ff});
               default: begin
                  rh = coord_type'({1'b0, h_ff});
                  rx = x_ff + coord_type'({1'b0, w_ff}) - coord_type'(1);
               end
            endcase
         end
         FN_GLYPH, FN_CGLYPH: rw = cmin(coord_type'({1'b0, w_ff}), coord_type'(8));
         default: ;
      endcase
      sx0 = cmax(rx, '0);
      sy0 = cmax(ry, '0);
      sx1 = cmin(rx + rw, lim_w);
      sy1 = cmin(ry + rh, lim_h);
      if (clipped) begin
         sx0 = cmax(sx0, cx);
         sy0 = cmax(sy0, cy);
         sx1 = cmin(sx1, cx + coord_type'({1'b0, clip_width_ff}));
         sy1 = cmin(sy1, cy + coord_type'({1'b0, clip_height_ff}));
      end
   end

   // pixel mask of the current word, plus the last-word and last-row flags
   always_comb begin
      c  = '0;
      gi = '0;
      for (int k = 0; k < WORD_BITS; k++) begin
         c  = (wcol_ff <<< 6) + coord_type'(k);
         gi = c - x_ff;
         mask[WORD_BITS-1-k] = (c >= x0_ff) && (c < x1_ff) && (!glyph || gb_ff[gi[2:0]]);
      end
      flip  = (func_ff == FN_INVERT) || (func_ff == FN_TOGGLE);
      wlast = ((wcol_ff + coord_type'(1)) <<< 6) >= x1_ff;
      rlast = (row_ff + coord_type'(1)) >= y1_ff;
   end

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      dv_in        = dv_ff;
      gb_in        = gb_ff;
      seg_in       = seg_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y1_in        = y1_ff;
      row_in       = row_ff;
      wcol_in      = wcol_ff;
      pix_in       = pix_ff;
      clr_in       = clr_ff;
      clr_cmd_in   = clr_cmd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_pix_in   = rsp_pix_ff;
      rsp_func_in  = rsp_func_ff;
      wr_en        = 1'b0;
      wr_addr      = word_addr;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = word_addr;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               clr_in   = '0;
               state_in = clr_cmd_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in    = req_tuser;
               x_in       = coord_type'($signed(req_tdata[11:0]));
               y_in       = coord_type'($signed(req_tdata[23:12]));
               w_in       = req_tdata[34:24];
               h_in       = req_tdata[45:35];
               dv_in      = req_tdata[46];
               gb_in      = req_tdata[54:47];
               seg_in     = '0;
               pix_in     = 1'b0;
               clr_cmd_in = 1'b1;
               if (req_tuser == FN_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if (req_tuser > FN_CGLYPH) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            x0_in   = sx0;
            x1_in   = sx1;
            y1_in   = sy1;
            row_in  = sy0;
            wcol_in = sx0 >>> 6;
            if (seg_ok && (sx0 < sx1) && (sy0 < sy1)) begin
               state_in = ST_READ;
            end else if (seg_last) begin
               state_in = ST_DONE;
            end else begin
               seg_in = seg_ff + 2'd1;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MODIFY;
         end
         ST_MODIFY: begin
            if (func_ff == FN_GET) begin
               pix_in = |(rd_data & mask);
            end else begin
               wr_en = 1'b1;
               if (flip) begin
                  wr_data = rd_data ^ mask;
               end else if (dv_ff) begin
                  wr_data = rd_data | mask;
               end else begin
                  wr_data = rd_data & ~mask;
               end
            end
            if (wlast && rlast) begin
               if (seg_last) begin
                  state_in = ST_DONE;
               end else begin
                  seg_in   = seg_ff + 2'd1;
                  state_in = ST_SETUP;
               end
            end else if (wlast) begin
               row_in   = row_ff + coord_type'(1);
               wcol_in  = x0_ff >>> 6;
               state_in = ST_READ;
            end else begin
               wcol_in  = wcol_ff + coord_type'(1);
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = pix_ff;
               rsp_func_in  = func_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   mfb_store #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

// ===== rtl/mfb_checker.sv =====
// port-level checks of the drawing engine, bound to the top level
`include "mono_framebuffer_draw_engine_defines.svh"

module mfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser
);
   import mfb_pkg::*;

   `MFB_ASSERT_NXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)
   `MFB_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `MFB_ASSERT_IMP(a_pix_only_get, rsp_tvalid && (rsp_tuser != FN_GET), rsp_tdata[0] == 1'b0)
   `MFB_ASSERT_IMP(a_pad_zero, rsp_tvalid, rsp_tdata[7:1] == 7'd0)

endmodule

bind mono_framebuffer_draw_engine mfb_checker u_mfb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

// ===== sim/mono_framebuffer_draw_engine_tb.sv =====
// testbench for the frame store drawing engine: random and directed commands against a pixel model
`timescale 1ns / 100ps

module mono_framebuffer_draw_engine_tb;
   import mfb_pkg::*;

   localparam int FB_W = DEF_MAX_WIDTH;
   localparam int FB_H = DEF_MAX_HEIGHT;
   localparam int ITEMS_PER_PHASE = 115;

   localparam int MODE_CLEAR = 0;
   localparam int MODE_SET   = 1;
   localparam int MODE_FLIP  = 2;

   typedef struct packed {
      logic [3:0]  func;
      logic [11:0] x_pos;
      logic [11:0] y_pos;
      logic [10:0] span_width;
      logic [10:0] span_height;
      logic        draw_value;
      logic [7:0]  glyph_bits;
   } draw_cmd_type;

   typedef struct packed {
      logic       pixel_out;
      logic [3:0] done_func;
   } draw_rsp_type;

   class frame_model;
      bit            pixels[FB_H][FB_W];
      int            frame_w, frame_h, clip_x, clip_y, clip_w, clip_h;
      draw_rsp_type  pending_rsp[$];

      function new();
         frame_w = RST_FRAME_WIDTH;
         frame_h = RST_FRAME_HEIGHT;
         clip_x  = 0;
         clip_y  = 0;
         clip_w  = RST_CLIP_WIDTH;
         clip_h  = RST_CLIP_HEIGHT;
      endfunction

      function void write_reg(logic [2:0] idx, logic [11:0] val);
         case (idx)
            CSR_FRAME_WIDTH:  frame_w = val[9:0];
            CSR_FRAME_HEIGHT: frame_h = val[8:0];
            CSR_CLIP_LEFT:    clip_x  = $signed(val);
            CSR_CLIP_TOP:     clip_y  = $signed(val);
            CSR_CLIP_WIDTH:   clip_w  = val[10:0];
            CSR_CLIP_HEIGHT:  clip_h  = val[10:0];
            default: ;
         endcase
      endfunction

      function int lim_w();
         return (frame_w < FB_W) ? frame_w : FB_W;
      endfunction

      function int lim_h();
         return (frame_h < FB_H) ? frame_h : FB_H;
      endfunction

      function bit in_frame(int x, int y);
         return x >= 0 && y >= 0 && x < lim_w() && y < lim_h();
      endfunction

      function void paint(int x, int y, int mode);
         if (!in_frame(x, y)) return;
         if (mode == MODE_FLIP) pixels[y][x] = !pixels[y][x];
         else pixels[y][x] = (mode == MODE_SET);
      endfunction

      function void paint_area(int x, int y, int w, int h, int mode);
         int x0, y0, x1, y1;
         x0 = (x < 0) ? 0 : x;
         y0 = (y < 0) ? 0 : y;
         x1 = (x + w > lim_w()) ? lim_w() : x + w;
         y1 = (y + h > lim_h()) ? lim_h() : y + h;
         for (int j = y0; j < y1; j++)
            for (int i = x0; i < x1; i++)
               paint(i, j, mode);
      endfunction

      function void apply_cmd(draw_cmd_type c);
         int x, y, w, h, mode, n, px;
         draw_rsp_type r;
         x = $signed(c.x_pos);
         y = $signed(c.y_pos);
         w = c.span_width;
         h = c.span_height;
         mode = c.draw_value ? MODE_SET : MODE_CLEAR;
         r.pixel_out = 1'b0;
         r.done_func = c.func;
         case (c.func)
            FN_CLEAR:   pixels = '{default: '0};
            FN_PUT:     paint(x, y, mode);
            FN_GET:     r.pixel_out = in_frame(x, y) ? pixels[y][x] : 1'b0;
            FN_TOGGLE:  paint(x, y, MODE_FLIP);
            FN_HLINE:   paint_area(x, y, w, 1, mode);
            FN_VLINE:   paint_area(x, y, 1, h, mode);
            FN_FILL:    paint_area(x, y, w, h, mode);
            FN_INVERT:  paint_area(x, y, w, h, MODE_FLIP);
            FN_OUTLINE: begin
               if (w > 0 && h > 0) begin
                  paint_area(x, y, w, 1, mode);
                  paint_area(x, y + h - 1, w, 1, mode);
                  paint_area(x, y, 1, h, mode);
                  paint_area(x + w - 1, y, 1, h, mode);
               end
            end
            FN_GLYPH, FN_CGLYPH: begin
               n = (w < 8) ? w : 8;
               for (int i = 0; i < n; i++) begin
                  px = x + i;
                  if (!c.glyph_bits[i]) continue;
                  if (c.func == FN_CGLYPH && (px < clip_x || y < clip_y ||
                      px >= clip_x + clip_w || y >= clip_y + clip_h)) continue;
                  paint(px, y, mode);
               end
            end
            default: ;
         endcase
         pending_rsp.push_back(r);
      endfunction

      // returns 0 when nothing was waiting
      function bit check_rsp(output draw_rsp_type want);
         if (pending_rsp.size() == 0) return 0;
         want = pending_rsp.pop_front();
         return 1;
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [11:0] csr_data = '0;

   frame_model model = new();
   int  error_count = 0;
   int  cmds_sent = 0;
   int  rsps_seen = 0;
   int  gets_seen = 0;
   bit  hold_rsp = 1'b0;
   int  rsp_stall = 0;

   mono_framebuffer_draw_engine u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver with random stalls (not for 300 < cmds_sent < 500), plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset || hold_rsp) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (cmds_sent > 300 && cmds_sent < 500) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_stall <= pick_gap();
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      draw_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsps_seen++;
         if (!model.check_rsp(want)) begin
            report($sformatf("unexpected item func=%0d", rsp_tuser));
         end else begin
            if (rsp_tuser !== want.done_func)
               report($sformatf("done_func %0d, want %0d", rsp_tuser, want.done_func));
            if (rsp_tdata !== {7'd0, want.pixel_out})
               report($sformatf("pixel_out %0h, want %0d (func %0d)",
                                rsp_tdata, want.pixel_out, want.done_func));
            if (want.done_func == FN_GET) gets_seen++;
         end
      end
   end

   task automatic send_cmd(input draw_cmd_type c, input int gap);
      req_tvalid <= 1'b1;
      req_tuser  <= c.func;
      req_tdata  <= {1'b0, c.glyph_bits, c.draw_value, c.span_height, c.span_width,
                     c.y_pos, c.x_pos};
      do @(posedge clock); while (!req_tready);
      model.apply_cmd(c);
      cmds_sent++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [11:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      model.write_reg(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (model.pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic draw_cmd_type mk(input logic [3:0] f, input int x, input int y,
                                       input int w, input int h, input bit v,
                                       input logic [7:0] g);
      draw_cmd_type c;
      c.func = f;
      c.x_pos = x[11:0];
      c.y_pos = y[11:0];
      c.span_width = w[10:0];
      c.span_height = h[10:0];
      c.draw_value = v;
      c.glyph_bits = g;
      return c;
   endfunction

   function automatic logic [11:0] pick_coord(input int lim);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 4095);
      return $urandom_range(0, lim + 16) - 8;
   endfunction

   function automatic logic [10:0] pick_size();
      if ($urandom_range(0, 24) == 0) return $urandom_range(0, 2047);
      return $urandom_range(0, 24);
   endfunction

   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int r;
      r = $urandom_range(0, 199);
      if (r < 2)       c.func = FN_CLEAR;
      else if (r < 8)  c.func = $urandom_range(11, 15);
      else             c.func = $urandom_range(1, 10);
      c.x_pos = pick_coord(model.lim_w());
      c.y_pos = pick_coord(model.lim_h());
      c.span_width = pick_size();
      c.span_height = pick_size();
      c.draw_value = $urandom_range(0, 1);
      c.glyph_bits = $urandom_range(0, 255);
      return c;
   endfunction

   task automatic set_frame(input int fw, input int fh, input int cx, input int cy,
                            input int cw, input int ch);
      wait_drained();
      write_csr(CSR_FRAME_WIDTH, fw[11:0]);
      write_csr(CSR_FRAME_HEIGHT, fh[11:0]);
      write_csr(CSR_CLIP_LEFT, cx[11:0]);
      write_csr(CSR_CLIP_TOP, cy[11:0]);
      write_csr(CSR_CLIP_WIDTH, cw[11:0]);
      write_csr(CSR_CLIP_HEIGHT, ch[11:0]);
   endtask

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++)
         send_cmd(random_cmd(), ($urandom_range(0, 3) == 0) ? 0 : pick_gap());
   endtask

   // long receiver hold-off while the sender keeps going
   initial begin
      wait (cmds_sent == 150);
      hold_rsp = 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp = 1'b0;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part
      send_cmd(mk(FN_PUT, 0, 0, 0, 0, 1, 0), 0);
      send_cmd(mk(FN_PUT, 511, 255, 0, 0, 1, 0), 1);
      send_cmd(mk(FN_GET, 511, 255, 0, 0, 0, 0), 0);
      send_cmd(mk(FN_TOGGLE, 0, 0, 0, 0, 0, 0), 0);
      send_cmd(mk(FN_GET, 0, 0, 0, 0, 0, 0), 0);
      send_cmd(mk(FN_PUT, -1, 5, 0, 0, 1, 0), 0);
      send_cmd(mk(FN_GET, -2048, 2047, 0, 0, 0, 0), 2);
      send_cmd(mk(FN_HLINE, -5, 3, 2047, 2047, 1, 8'hff), 0);
      send_cmd(mk(FN_VLINE, 7, -3, 0, 10, 1, 0), 0);
      send_cmd(mk(FN_GET, 7, 3, 0, 0, 0, 0), 0);
      send_cmd(mk(FN_FILL, 60, 10, 70, 5, 1, 0), 0);
      send_cmd(mk(FN_INVERT, 62, 12, 9, 9, 0, 0), 0);
      send_cmd(mk(FN_GET, 63, 12, 0, 0, 0, 0), 0);
      send_cmd(mk(FN_OUTLINE, 20, 20, 0, 5, 1, 0), 0);
      send_cmd(mk(FN_OUTLINE, 30, 30, 1, 1, 1, 0), 0);
      send_cmd(mk(FN_OUTLINE, 500, 250, 20, 20, 1, 0), 0);
      send_cmd(mk(FN_GLYPH, 508, 40, 2047, 0, 1, 8'hff), 0);
      send_cmd(mk(FN_GLYPH, 100, 40, 3, 9, 1, 8'ha5), 0);
      send_cmd(mk(FN_CGLYPH, -4, 41, 8, 0, 1, 8'hff), 0);
      send_cmd(mk(FN_GET, 0, 41, 0, 0, 0, 0), 0);
      send_cmd(mk(4'd15, 1, 1, 5, 5, 1, 8'hff), 0);
      send_cmd(mk(FN_CLEAR, 0, 0, 0, 0, 0, 0), 0);
      send_cmd(mk(FN_GET, 511, 255, 0, 0, 0, 0), 0);
      req_tvalid <= 1'b0;

      run_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;
      set_frame(1023, 511, -2048, -2048, 2047, 2047);
      run_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;
      set_frame(1, 1, 2047, 2047, 0, 0);
      run_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;
      set_frame(37, 19, 3, 2, 20, 9);
      run_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;
      set_frame(0, 256, 0, 0, 512, 256);
      run_random(40);
      req_tvalid <= 1'b0;
      set_frame(512, 0, 0, 0, 512, 256);
      run_random(40);
      req_tvalid <= 1'b0;
      set_frame(200, 100, -5, -3, 100, 60);
      run_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;
      set_frame(512, 256, 1000, -1000, 1024, 1500);
      run_random(ITEMS_PER_PHASE);
      req_tvalid <= 1'b0;

      wait_drained();
      $display("run covered %0d commands over 8 register settings, %0d responses, %0d reads",
               cmds_sent, rsps_seen, gets_seen);
      if (error_count == 0) begin
         $display("[mono_framebuffer_draw_engine] OK");
      end else begin
         $display("%0d mismatches", error_count);
         $display("[mono_framebuffer_draw_engine] ERROR");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("timeout with %0d responses outstanding", model.pending_rsp.size());
      $display("[mono_framebuffer_draw_engine] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mfb_pkg.sv
rtl/mfb_store.sv
rtl/mono_framebuffer_draw_engine.sv
rtl/mfb_checker.sv
sim/mono_framebuffer_draw_engine_tb.sv
